/* hw/rtl/bounded_stack_with_search_defines.svh */
// Assertion macros shared by the bounded stack RTL.
// No dependencies; each macro expects signals named clk and rst_n in scope.
`ifndef BOUNDED_STACK_WITH_SEARCH_DEFINES_SVH
`define BOUNDED_STACK_WITH_SEARCH_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BSWS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BSWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/bsws_pkg.sv */
// Shared constants for the bounded stack with search: field widths,
// operation and status codes, and default sizes. No dependencies.
package bsws_pkg;

  localparam int WORD_W   = 32;
  localparam int OPCODE_W = 3;
  localparam int STATUS_W = 2;
  localparam int DIST_W   = 6;
  localparam int COUNT_W  = 7;
  localparam int CAP_W    = 7;

  localparam int DEPTH_DEF = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [OPCODE_W-1:0] OP_PUSH        = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_POP         = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SEARCH      = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_PEEK_TOP    = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_PEEK_BOTTOM = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

/* hw/rtl/bsws_fcmp.sv */
// IEEE single-precision equality compare used by the search walk.
// Depends on bsws_pkg for the word width.
module bsws_fcmp (
  input  logic [bsws_pkg::WORD_W-1:0] a,
  input  logic [bsws_pkg::WORD_W-1:0] b,
  output logic                        eq
);
  import bsws_pkg::*;

  localparam logic [WORD_W-1:0] MAG_MASK = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] INF_MAG  = 32'h7F80_0000;

  logic [WORD_W-1:0] a_mag;
  logic [WORD_W-1:0] b_mag;
  logic              any_nan;
  logic              both_zero;

  assign a_mag = a & MAG_MASK;
  assign b_mag = b & MAG_MASK;

  // A NaN matches nothing, and the two signed zeros match each other.
  assign any_nan   = (a_mag > INF_MAG) || (b_mag > INF_MAG);
  assign both_zero = (a_mag == '0) && (b_mag == '0);
  assign eq        = !any_nan && (both_zero || (a == b));

endmodule

/* hw/rtl/bsws_store.sv */
// Entry storage for the stack: one write port and one registered read port.
// Depends on bsws_pkg for the word width.
module bsws_store #(
  parameter int DEPTH = bsws_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [$clog2(DEPTH)-1:0]    wr_addr,
  input  logic [bsws_pkg::WORD_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [$clog2(DEPTH)-1:0]    rd_addr,
  output logic [bsws_pkg::WORD_W-1:0] rd_data
);
  import bsws_pkg::*;

  logic [WORD_W-1:0] mem_r [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/bounded_stack_with_search.sv */
// Bounded LIFO stack of IEEE single words with a top-down search.
// Depends on bsws_pkg, bsws_store, bsws_fcmp and the assertion macro header.
//
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_stall    | opcode, operand_word
//   out_    | output    | out_valid / out_stall  | status, data_word,
//           |           |                        | depth_below_top, entry_count,
//           |           |                        | free_space
//   cfg_    | input     | cfg_wr_en              | cfg_wr_data (capacity)
//
// Push, unused opcodes and any request on an empty stack go from idle straight
// to the final state; pop and the peeks first pass through a read state, for
// the registered read port of the entry memory. A search steps down from the
// top until a hit or the bottom entry: the walk reads one entry per cycle
// through the single read port and the one compare unit.
// Reset clears the count and sets the capacity to 64; entry contents are kept.
// A stalled result holds the block in its final state until the result is taken.
`include "bounded_stack_with_search_defines.svh"

module bounded_stack_with_search #(
  parameter int DEPTH = bsws_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bsws_pkg::CAP_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bsws_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [bsws_pkg::WORD_W-1:0]   in_operand_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bsws_pkg::STATUS_W-1:0] out_status,
  output logic [bsws_pkg::WORD_W-1:0]   out_data_word,
  output logic [bsws_pkg::DIST_W-1:0]   out_depth_below_top,
  output logic [bsws_pkg::COUNT_W-1:0]  out_entry_count,
  output logic [bsws_pkg::COUNT_W-1:0]  out_free_space
);
  import bsws_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [CAP_W-1:0]    cap_r;
  logic [CW-1:0]       count_r;
  logic [WORD_W-1:0]   word_r;
  logic [AW-1:0]       ptr_r;
  logic [AW-1:0]       idx_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [WORD_W-1:0]   res_data_r;
  logic [DIST_W-1:0]   res_dist_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [WORD_W-1:0]   out_data_r;
  logic [DIST_W-1:0]   out_dist_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic [COUNT_W-1:0]  out_free_r;

  logic                in_fire;
  logic                out_load;
  logic                empty;
  logic                full;
  logic [CW-1:0]       count_dec;
  logic [AW-1:0]       top_addr;
  logic [EW-1:0]       cap_e;
  logic [EW-1:0]       eff_cap;
  logic [EW-1:0]       count_e;
  logic [EW-1:0]       free_e;
  logic [31:0]         free_ext;
  logic [31:0]         count_ext;
  logic [31:0]         idx_ext;

  logic                wr_en;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [WORD_W-1:0]   rd_data;
  logic                hit;

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign empty     = (count_r == '0);
  assign count_dec = count_r - CW'(1);
  assign top_addr  = count_dec[AW-1:0];

  // The effective capacity never exceeds the physical depth.
  assign cap_e   = EW'(cap_r);
  assign count_e = EW'(count_r);
  assign eff_cap = (cap_e > DEPTH_E) ? DEPTH_E : cap_e;
  assign full    = (count_e >= eff_cap);
  assign free_e  = (eff_cap > count_e) ? (eff_cap - count_e) : '0;

  assign free_ext  = 32'(free_e);
  assign count_ext = 32'(count_r);
  assign idx_ext   = 32'(idx_r);

  assign wr_en = in_fire && (in_opcode == OP_PUSH) && !full;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = top_addr;
    case (state_r)
      S_IDLE: begin
        rd_en   = in_fire && !empty &&
                  (in_opcode inside {OP_POP, OP_SEARCH, OP_PEEK_TOP, OP_PEEK_BOTTOM});
        rd_addr = (in_opcode == OP_PEEK_BOTTOM) ? '0 : top_addr;
      end
      S_SCAN: begin
        // Fetch the next entry down while the current one is compared.
        rd_en   = (ptr_r != '0);
        rd_addr = ptr_r - AW'(1);
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = top_addr;
      end
    endcase
  end

  bsws_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_operand_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bsws_fcmp u_fcmp (
    .a  (rd_data),
    .b  (word_r),
    .eq (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            word_r       <= in_operand_word;
            res_status_r <= ST_OK;
            res_data_r   <= '0;
            res_dist_r   <= '0;
            state_r      <= S_DONE;
            case (in_opcode)
              OP_PUSH: begin
                if (full) begin
                  res_status_r <= ST_FULL;
                end else begin
                  count_r <= count_r + CW'(1);
                end
              end
              OP_POP: begin
                if (empty) begin
                  res_status_r <= ST_EMPTY;
                end else begin
                  count_r <= count_dec;
                  state_r <= S_READ;
                end
              end
              OP_SEARCH: begin
                if (empty) begin
                  res_status_r <= ST_EMPTY;
                end else begin
                  ptr_r   <= top_addr;
                  idx_r   <= '0;
                  state_r <= S_SCAN;
                end
              end
              OP_PEEK_TOP, OP_PEEK_BOTTOM: begin
                if (empty) begin
                  res_status_r <= ST_EMPTY;
                end else begin
                  state_r <= S_READ;
                end
              end
              default: begin
                res_status_r <= ST_OK;
              end
            endcase
          end
        end
        S_READ: begin
          res_data_r <= rd_data;
          state_r    <= S_DONE;
        end
        S_SCAN: begin
          if (hit) begin
            res_status_r <= ST_OK;
            res_dist_r   <= idx_ext[DIST_W-1:0];
            state_r      <= S_DONE;
          end else if (ptr_r == '0) begin
            res_status_r <= ST_NOTFOUND;
            state_r      <= S_DONE;
          end else begin
            ptr_r <= ptr_r - AW'(1);
            idx_r <= idx_r + AW'(1);
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_status_r <= res_status_r;
            out_data_r   <= res_data_r;
            out_dist_r   <= res_dist_r;
            out_count_r  <= count_ext[COUNT_W-1:0];
            out_free_r   <= free_ext[COUNT_W-1:0];
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_data_word       = out_data_r;
  assign out_depth_below_top = out_dist_r;
  assign out_entry_count     = out_count_r;
  assign out_free_space      = out_free_r;

  `BSWS_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "count exceeds depth")
  `BSWS_ASSERT_NEXT(a_count_hold, !in_fire, $stable(count_r), "count moved without an item")
  `BSWS_ASSERT_SAME(a_scan_track, state_r == S_SCAN,
    (CW'(idx_r) + CW'(ptr_r)) == count_dec, "scan pointer and distance disagree")
  `BSWS_ASSERT_SAME(a_result_src, out_valid_r && !$past(out_valid_r),
    $past(state_r) == S_DONE, "result raised outside the final state")
  `BSWS_ASSERT_NEXT(a_busy_after_accept, in_fire, in_stall, "item accepted while idle stays")

endmodule
